[src/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

[src/dpsc_pkg.sv]
`default_nettype none
package dpsc_pkg;

   // Width of every count on the result side
   localparam int COUNT_W = 17;

   typedef logic [COUNT_W-1:0] count_type;

   // Class of one site as decided by the front end
   typedef enum logic [2:0] {
      CLASS_NONE,
      CLASS_IDENT,
      CLASS_PURINE,
      CLASS_PYRIM,
      CLASS_TRANSV
   } site_class_type;

   // Word carried from front end to back end
   typedef struct packed {
      site_class_type kind;
      logic           last;
   } site_word_type;

   // Word carried from back end to the result queue
   typedef struct packed {
      count_type purine;
      count_type pyrimidine;
      count_type transversion;
      count_type identity;
      count_type active;
   } result_word_type;

endpackage
`default_nettype wire

[src/dna_pair_substitution_counter.sv]
// A result word reaches the rsp_ ports once its last site has passed the site queue
// and the back end has written its counts into the result queue. Throughput: one site
// word per cycle while the site queue is not full; a 4-entry site queue parts front
// and back end, and a 2-entry result queue holds finished counts until popped.
// The back end stalls only when a last site meets a full result queue.
// Reset (synchronous, active high) empties both queues and clears all five counters.
`default_nettype none
module dna_pair_substitution_counter
   import dpsc_pkg::*;
#(
   parameter int unsigned MAX_SITES = 65536
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire logic [7:0]   req_base_first,
   input  wire logic [7:0]   req_base_second,
   input  wire logic         req_site_enabled,
   input  wire logic         req_last_site,
   output logic              empty,
   input  wire logic         pop,
   output logic [16:0]       rsp_purine_transitions,
   output logic [16:0]       rsp_pyrimidine_transitions,
   output logic [16:0]       rsp_transversions,
   output logic [16:0]       rsp_identical_sites,
   output logic [16:0]       rsp_active_sites
);

   localparam int SITE_DEPTH = 4;
   localparam int RES_DEPTH  = 2;
   localparam int SITE_W     = $bits(site_word_type);
   localparam int RES_W      = $bits(result_word_type);

   logic            front_push;
   site_word_type   front_word;
   logic            site_full;
   logic            site_empty;
   logic            site_pop;
   logic [SITE_W-1:0] site_bits;
   site_word_type   site_word;
   logic            res_full;
   logic            res_push;
   result_word_type res_word;
   logic [RES_W-1:0] out_bits;
   result_word_type out_word;

   // Classify incoming sites
   dpsc_front u_front (
      .push         (push),
      .base_first   (req_base_first),
      .base_second  (req_base_second),
      .site_enabled (req_site_enabled),
      .last_site    (req_last_site),
      .queue_full   (site_full),
      .queue_push   (front_push),
      .queue_word   (front_word)
   );

   assign full = site_full;

   // Site queue between front and back end
   dpsc_queue #(
      .WIDTH (SITE_W),
      .DEPTH (SITE_DEPTH)
   ) u_site_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_push),
      .wr_word (front_word),
      .full    (site_full),
      .rd_en   (site_pop),
      .rd_word (site_bits),
      .empty   (site_empty)
   );

   assign site_word = site_word_type'(site_bits);

   // Counters
   dpsc_back #(
      .MAX_SITES (MAX_SITES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .site_word  (site_word),
      .site_empty (site_empty),
      .site_pop   (site_pop),
      .res_full   (res_full),
      .res_push   (res_push),
      .res_word   (res_word)
   );

   // Result queue
   dpsc_queue #(
      .WIDTH (RES_W),
      .DEPTH (RES_DEPTH)
   ) u_res_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_word (res_word),
      .full    (res_full),
      .rd_en   (pop),
      .rd_word (out_bits),
      .empty   (empty)
   );

   assign out_word                   = result_word_type'(out_bits);
   assign rsp_purine_transitions     = out_word.purine;
   assign rsp_pyrimidine_transitions = out_word.pyrimidine;
   assign rsp_transversions          = out_word.transversion;
   assign rsp_identical_sites        = out_word.identity;
   assign rsp_active_sites           = out_word.active;

endmodule
`default_nettype wire

[src/dpsc_front.sv]
`default_nettype none
module dpsc_front
   import dpsc_pkg::*;
(
   input  wire logic          push,
   input  wire logic [7:0]    base_first,
   input  wire logic [7:0]    base_second,
   input  wire logic          site_enabled,
   input  wire logic          last_site,
   input  wire logic          queue_full,
   output logic               queue_push,
   output site_word_type      queue_word
);

   // ASCII base letters
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   // 2-bit base codes; bit 0 clear marks a purine
   localparam logic [1:0] CODE_A = 2'd0;
   localparam logic [1:0] CODE_C = 2'd1;
   localparam logic [1:0] CODE_G = 2'd2;
   localparam logic [1:0] CODE_T = 2'd3;

   logic [1:0] code_a;
   logic [1:0] code_b;
   logic       ok_a;
   logic       ok_b;

   // Decode first base
   always_comb begin
      ok_a   = 1'b1;
      code_a = CODE_A;
      case (base_first)
         CHAR_A: code_a = CODE_A;
         CHAR_C: code_a = CODE_C;
         CHAR_G: code_a = CODE_G;
         CHAR_T: code_a = CODE_T;
         default: ok_a = 1'b0;
      endcase
   end

   // Decode second base
   always_comb begin
      ok_b   = 1'b1;
      code_b = CODE_A;
      case (base_second)
         CHAR_A: code_b = CODE_A;
         CHAR_C: code_b = CODE_C;
         CHAR_G: code_b = CODE_G;
         CHAR_T: code_b = CODE_T;
         default: ok_b = 1'b0;
      endcase
   end

   // Classify the site; disabled sites, gaps, unknowns and other bytes drop it
   always_comb begin
      queue_word.last = last_site;
      if (!(site_enabled && ok_a && ok_b)) begin
         queue_word.kind = CLASS_NONE;
      end else if (code_a == code_b) begin
         queue_word.kind = CLASS_IDENT;
      end else if (code_a[0] != code_b[0]) begin
         queue_word.kind = CLASS_TRANSV;
      end else if (!code_a[0]) begin
         queue_word.kind = CLASS_PURINE;
      end else begin
         queue_word.kind = CLASS_PYRIM;
      end
   end

   assign queue_push = push && !queue_full;

endmodule
`default_nettype wire

[src/dpsc_queue.sv]
`default_nettype none
`include "assert_macros.svh"
module dpsc_queue #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_word,
   output logic                  full,
   input  wire logic             rd_en,
   output logic [WIDTH-1:0]      rd_word,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr;
   logic             do_rd;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_word = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_word;
      end
   end

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > FULL_CNT)
   `ASSERT_HOLDS(a_count_up, clock, reset,
                 (do_wr && !do_rd) |=> (count_ff == $past(count_ff) + 1'b1))
   `ASSERT_HOLDS(a_ptr_gap, clock, reset,
                 (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))

endmodule
`default_nettype wire

[src/dpsc_back.sv]
`default_nettype none
`include "assert_macros.svh"
module dpsc_back
   import dpsc_pkg::*;
#(
   parameter int unsigned MAX_SITES = 65536
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire site_word_type   site_word,
   input  wire logic            site_empty,
   output logic                 site_pop,
   input  wire logic            res_full,
   output logic                 res_push,
   output result_word_type      res_word
);

   localparam longint unsigned FIELD_MAX = (64'd1 << COUNT_W) - 64'd1;
   localparam count_type COUNT_CAP = (longint'(MAX_SITES) < FIELD_MAX) ?
                                     COUNT_W'(MAX_SITES) : COUNT_W'(FIELD_MAX);

   result_word_type counts_ff, counts_in;
   result_word_type next_counts;
   logic            take;

   function automatic count_type sat_inc(input count_type c, input logic hit);
      sat_inc = (hit && (c < COUNT_CAP)) ? c + 1'b1 : c;
   endfunction

   // A last site needs room in the result queue
   assign take     = !site_empty && !(site_word.last && res_full);
   assign site_pop = take;
   assign res_push = take && site_word.last;

   // Counts after this site
   always_comb begin
      next_counts.active = sat_inc(counts_ff.active, site_word.kind != CLASS_NONE);
      next_counts.identity = sat_inc(counts_ff.identity, site_word.kind == CLASS_IDENT);
      next_counts.transversion =
         sat_inc(counts_ff.transversion, site_word.kind == CLASS_TRANSV);
      next_counts.purine = sat_inc(counts_ff.purine, site_word.kind == CLASS_PURINE);
      next_counts.pyrimidine =
         sat_inc(counts_ff.pyrimidine, site_word.kind == CLASS_PYRIM);
   end

   assign res_word = next_counts;

   // Clear after the last site of a pair
   always_comb begin
      counts_in = counts_ff;
      if (take) begin
         counts_in = site_word.last ? '0 : next_counts;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff <= '0;
      end else begin
         counts_ff <= counts_in;
      end
   end

   `ASSERT_NEVER(a_cap, clock, reset, counts_ff.active > COUNT_CAP)
   `ASSERT_NEVER(a_ident_le_active, clock, reset,
                 counts_ff.identity > counts_ff.active)
   `ASSERT_HOLDS(a_clear_after_last, clock, reset,
                 (take && site_word.last) |=> (counts_ff == '0))

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
   import dpsc_pkg::*;

   // counters in the block stop at the smaller of MAX_SITES and the field maximum
   localparam int unsigned COUNT_CAP = 65536;
   localparam int          PHASE_SITES = 140;

   typedef enum int {NUC_A, NUC_C, NUC_G, NUC_T, NUC_OTHER} nuc_type;

   // running pair counts and the count words still owed by the block
   class tally_board;
      result_word_type running;
      result_word_type due_q[$];
      int unsigned     mismatches;
      int unsigned     words_seen;

      function new();
         running    = '0;
         mismatches = 0;
         words_seen = 0;
      endfunction

      function nuc_type nuc_of(logic [7:0] ch);
         case (ch)
            "A":     return NUC_A;
            "C":     return NUC_C;
            "G":     return NUC_G;
            "T":     return NUC_T;
            default: return NUC_OTHER;
         endcase
      endfunction

      function bit is_purine(nuc_type n);
         return (n == NUC_A) || (n == NUC_G);
      endfunction

      function count_type capped_inc(count_type c);
         return (c < COUNT_CAP) ? c + 1'b1 : c;
      endfunction

      // classify one accepted site, bump counts, queue a word on the last site
      function void note_site(logic [7:0] b1, logic [7:0] b2, logic en, logic lst);
         nuc_type        x;
         nuc_type        y;
         site_class_type kind;
         x    = nuc_of(b1);
         y    = nuc_of(b2);
         kind = CLASS_NONE;
         if (en && x != NUC_OTHER && y != NUC_OTHER) begin
            if (x == y)
               kind = CLASS_IDENT;
            else if (is_purine(x) != is_purine(y))
               kind = CLASS_TRANSV;
            else if (is_purine(x))
               kind = CLASS_PURINE;
            else
               kind = CLASS_PYRIM;
         end
         if (kind != CLASS_NONE)
            running.active = capped_inc(running.active);
         case (kind)
            CLASS_IDENT:  running.identity     = capped_inc(running.identity);
            CLASS_TRANSV: running.transversion = capped_inc(running.transversion);
            CLASS_PURINE: running.purine       = capped_inc(running.purine);
            CLASS_PYRIM:  running.pyrimidine   = capped_inc(running.pyrimidine);
            default: ;
         endcase
         if (lst) begin
            due_q.push_back(running);
            running = '0;
         end
      endfunction

      function void field_check(string name, count_type want, count_type seen);
         if (want !== seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            mismatches++;
         end
      endfunction

      function void check_word(result_word_type got);
         result_word_type want;
         words_seen++;
         if (due_q.size() == 0) begin
            $error("count word with nothing expected: act %0d", got.active);
            mismatches++;
            return;
         end
         want = due_q.pop_front();
         field_check("purine_transitions", want.purine, got.purine);
         field_check("pyrimidine_transitions", want.pyrimidine, got.pyrimidine);
         field_check("transversions", want.transversion, got.transversion);
         field_check("identical_sites", want.identity, got.identity);
         field_check("active_sites", want.active, got.active);
      endfunction

      function int pending();
         return due_q.size();
      endfunction

      function void finish();
         if (due_q.size() != 0) begin
            $error("%0d count words never arrived", due_q.size());
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic [7:0]  req_base_first = 8'h00;
   logic [7:0]  req_base_second = 8'h00;
   logic        req_site_enabled = 1'b0;
   logic        req_last_site = 1'b0;
   logic        full;
   logic        empty;
   logic [16:0] rsp_purine_transitions;
   logic [16:0] rsp_pyrimidine_transitions;
   logic [16:0] rsp_transversions;
   logic [16:0] rsp_identical_sites;
   logic [16:0] rsp_active_sites;

   tally_board  sb;
   int          send_pct = 0;
   int          stall_pct = 0;
   int unsigned sites_sent = 0;

   dna_pair_substitution_counter i_dut (
      .clock                      (clock),
      .reset                      (reset),
      .push                       (push),
      .full                       (full),
      .req_base_first             (req_base_first),
      .req_base_second            (req_base_second),
      .req_site_enabled           (req_site_enabled),
      .req_last_site              (req_last_site),
      .empty                      (empty),
      .pop                        (pop),
      .rsp_purine_transitions     (rsp_purine_transitions),
      .rsp_pyrimidine_transitions (rsp_pyrimidine_transitions),
      .rsp_transversions          (rsp_transversions),
      .rsp_identical_sites        (rsp_identical_sites),
      .rsp_active_sites           (rsp_active_sites)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: random stalls, word taken at the edge after a negedge with pop && !empty
   always @(posedge clock) begin
      if (reset)
         pop <= 1'b0;
      else
         pop <= ($urandom_range(99) >= stall_pct);
   end

   always @(negedge clock) begin : take_word
      result_word_type got;
      if (!reset && pop && !empty) begin
         got = {rsp_purine_transitions, rsp_pyrimidine_transitions, rsp_transversions,
                rsp_identical_sites, rsp_active_sites};
         sb.check_word(got);
      end
   end

   function automatic logic [7:0] nuc_char(nuc_type n);
      case (n)
         NUC_A:   return "A";
         NUC_C:   return "C";
         NUC_G:   return "G";
         default: return "T";
      endcase
   endfunction

   // mostly real bases, some gap/unknown marks, lower case and raw bytes
   function automatic logic [7:0] pick_base();
      int r;
      r = $urandom_range(99);
      if (r < 80)
         return nuc_char(nuc_type'($urandom_range(3)));
      else if (r < 88)
         case ($urandom_range(2))
            0:       return "*";
            1:       return "?";
            default: return "-";
         endcase
      else if (r < 93)
         return nuc_char(nuc_type'($urandom_range(3))) | 8'h20;
      else
         return 8'($urandom_range(255));
   endfunction

   // push one site word, with an optional idle gap before it
   task automatic put_site(input logic [7:0] b1, input logic [7:0] b2,
                           input logic en, input logic lst);
      bit taken;
      if ($urandom_range(99) < send_pct) begin
         push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_pct);
      end
      push             <= 1'b1;
      req_base_first   <= b1;
      req_base_second  <= b2;
      req_site_enabled <= en;
      req_last_site    <= lst;
      do begin
         @(negedge clock);
         taken = !full;
         @(posedge clock);
      end while (!taken);
      sb.note_site(b1, b2, en, lst);
      sites_sent++;
   endtask

   // hold off the sender until every owed word has been popped
   task automatic drain_words();
      push <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // well-formed pair of random length; a stray early last mark now and then
   task automatic random_pair();
      int len;
      len = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 60);
      for (int n = 0; n < len; n++)
         put_site(pick_base(), pick_base(), $urandom_range(99) < 85,
                  (n == len - 1) || ($urandom_range(99) < 3));
   endtask

   initial begin
      int unsigned start_count;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // every base pairing in one pair, last site counted
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            put_site(nuc_char(nuc_type'(i)), nuc_char(nuc_type'(j)), 1'b1,
                     (i == 3) && (j == 3));
      // marks, lower case, raw bytes, disabled sites, inactive last site
      put_site("*", "A", 1'b1, 1'b0);
      put_site("C", "?", 1'b1, 1'b0);
      put_site("-", "-", 1'b1, 1'b0);
      put_site("a", "A", 1'b1, 1'b0);
      put_site(8'h00, 8'hFF, 1'b1, 1'b0);
      put_site("G", "G", 1'b0, 1'b0);
      put_site("T", "C", 1'b0, 1'b1);
      // single-site pair
      put_site("A", "G", 1'b1, 1'b1);
      drain_words();

      // random pairs under each idle mix
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               send_pct  = 76;
               stall_pct = 0;
            end
            2: begin
               send_pct  = 0;
               stall_pct = 76;
            end
            default: begin
               send_pct  = 32;
               stall_pct = 32;
            end
         endcase
         start_count = sites_sent;
         while (sites_sent - start_count < PHASE_SITES)
            random_pair();
         drain_words();
      end

      repeat (8) @(posedge clock);
      sb.finish();
      $display("summary: %0d sites sent, %0d count words checked", sites_sent,
               sb.words_seen);
      $display("summary: all base pairings, marks, odd bytes, disabled sites, four idle mixes");
      if (sb.mismatches == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #16000000;
      $display("tb: errors");
      $finish;
   end

endmodule
